// ----- rtl/sbe_pkg.sv -----
package sbe_pkg;

  localparam int PIX_W      = 8;
  localparam int COL_W      = 10;
  localparam int ROW_W      = 10;
  localparam int CFG_W      = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int MIN_SIZE   = 4;
  localparam int TAPS       = 5;
  localparam int TAP_W      = 3;
  localparam int LINES      = 4;
  localparam int SLOT_W     = 2;
  localparam int LINE_W     = LINES * PIX_W;
  localparam int LINE_AW    = $clog2(MAX_WIDTH);
  localparam int SUM_W      = PIX_W + 4;
  localparam int SHIFT      = 4;

  localparam logic [CFG_W-1:0] RST_WIDTH  = CFG_W'(640);
  localparam logic [CFG_W-1:0] RST_HEIGHT = CFG_W'(480);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1
  } cfg_reg_t;

  typedef logic [TAPS-1:0][PIX_W-1:0] tap_vec_t;

  function automatic logic [CFG_W-1:0] sat_size(input logic [CFG_W-1:0] v,
                                                input logic [CFG_W-1:0] maxv);
    logic [CFG_W-1:0] r;
    r = v;
    if (v < CFG_W'(MIN_SIZE)) r = CFG_W'(MIN_SIZE);
    else if (v > maxv) r = maxv;
    return r;
  endfunction

  // Fold a window offset into the frame: lo is the offset of the first
  // in-frame sample, offset TAPS-1 is always the last one available.
  function automatic logic [TAP_W-1:0] fold_tap(input logic [TAP_W-1:0] d,
                                                input logic [TAP_W-1:0] lo);
    logic [TAP_W-1:0] r;
    r = d;
    if (r < lo) r = lo;
    if (r > TAP_W'(TAPS - 1)) r = TAP_W'(TAPS - 1);
    return r;
  endfunction

  // 1-4-6-4-1 kernel, truncated by the shift
  function automatic logic [PIX_W-1:0] blur5(input tap_vec_t q);
    logic [SUM_W-1:0] s;
    s = SUM_W'(q[0]) + (SUM_W'(q[1]) << 2) + (SUM_W'(q[2]) << 2)
      + (SUM_W'(q[2]) << 1) + (SUM_W'(q[3]) << 2) + SUM_W'(q[4]);
    return s[SUM_W-1:SHIFT];
  endfunction

endpackage

// ----- rtl/sbe_ram.sv -----
module sbe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (re) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/separable_blur_5tap_edges.sv -----
// 5x5 separable blur (1-4-6-4-1 each way, >>4 per pass) with folded borders.
// Input channel: in_pixel words in raster order, in_valid/in_ready.
// Output channel: out_column/out_row/out_value/out_last words, out_valid/out_ready.
// out_last marks the final result caused by one input pixel.
// Config: cfg_we writes cfg_data to register cfg_index (0 width, 1 height);
// values are saturated to 4..1024 and a write to either register restarts the frame.
// Throughput: one pixel per cycle in steady state while the output is not
// stalled. The last pixel of a row holds the input for three column jobs; in
// the last row each column job yields three results, which slows that row.
// The column job stage does one read-modify-write of the line store per job;
// the store keeps four rows of horizontal results per column in one word.
// Reset: width 640, height 480, counters and pixel window cleared. The line
// store is not cleared; only rows written earlier in the frame are read.
// A stalled receiver holds the output register, then the column job stage,
// then the front stage and the input (in_ready low); nothing is dropped.
module separable_blur_5tap_edges
  import sbe_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [PIX_W-1:0]     in_pixel,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [COL_W-1:0]     out_column,
  output logic [ROW_W-1:0]     out_row,
  output logic [PIX_W-1:0]     out_value,
  output logic                 out_last,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  logic [CFG_W-1:0] w_size_r, h_size_r;
  logic [COL_W-1:0] col_r, w_last;
  logic [ROW_W-1:0] row_r, h_last;
  logic [LINES-1:0][PIX_W-1:0] win_r;
  logic in_fire, cfg_hit;

  // front stage: one pixel with its window, issues 1 or 3 column jobs
  logic                 f_valid_r;
  tap_vec_t             f_win_r;
  logic [COL_W-1:0]     f_c_r;
  logic [ROW_W-1:0]     f_y_r;
  logic [TAP_W-1:0]     f_lo_r, f_vlo_r;
  logic [1:0]           f_jcnt_r, f_jlast_r, f_kmax_r;
  logic                 f_emit_r;
  logic [TAPS-1:0][TAP_W-1:0] f_tap;
  tap_vec_t             f_q;
  logic [PIX_W-1:0]     f_h;
  logic [COL_W-1:0]     f_c;
  logic                 f_done;

  // column job stage: line store word, emits 0, 1 or 3 results
  logic                 v_valid_r;
  logic [COL_W-1:0]     v_c_r;
  logic [ROW_W-1:0]     v_rbase_r;
  logic [SLOT_W-1:0]    v_slot_r;
  logic [PIX_W-1:0]     v_h_r;
  logic [TAP_W-1:0]     v_lo_r;
  logic [1:0]           v_kcnt_r, v_kmax_r;
  logic                 v_emit_r, v_lastjob_r;
  logic [TAPS-1:0][TAP_W-1:0] v_tap;
  tap_vec_t             v_q;
  logic [LINES-1:0][PIX_W-1:0] rd_word, wr_word;
  logic [PIX_W-1:0]     v_value;
  logic                 v_step, v_done, v_load, v_kend;

  logic                 out_valid_r, out_last_r, out_free;
  logic [COL_W-1:0]     out_column_r;
  logic [ROW_W-1:0]     out_row_r;
  logic [PIX_W-1:0]     out_value_r;

  assign w_last   = COL_W'(w_size_r - CFG_W'(1));
  assign h_last   = ROW_W'(h_size_r - CFG_W'(1));
  assign in_ready = !f_valid_r || f_done;
  assign in_fire  = in_valid && in_ready;
  assign cfg_hit  = cfg_we && (cfg_index == REG_IMAGE_WIDTH ||
                               cfg_index == REG_IMAGE_HEIGHT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_size_r <= RST_WIDTH;
      h_size_r <= RST_HEIGHT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  w_size_r <= sat_size(cfg_data, CFG_W'(MAX_WIDTH));
        REG_IMAGE_HEIGHT: h_size_r <= sat_size(cfg_data, CFG_W'(MAX_HEIGHT));
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      win_r <= '0;
    end else if (cfg_hit) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_fire) begin
      win_r <= {in_pixel, win_r[LINES-1:1]};
      if (col_r >= w_last) begin
        col_r <= '0;
        row_r <= (row_r >= h_last) ? '0 : row_r + ROW_W'(1);
      end else begin
        col_r <= col_r + COL_W'(1);
      end
    end
  end

  // ---------------- front stage ----------------
  always_comb begin
    for (int i = 0; i < TAPS; i++) begin
      f_tap[i] = fold_tap(TAP_W'(i) + TAP_W'(f_jcnt_r), f_lo_r);
      f_q[i]   = f_win_r[f_tap[i]];
    end
    f_h = blur5(f_q);
    f_c = f_c_r + COL_W'(f_jcnt_r);
  end

  assign f_done = f_valid_r && v_load && (f_jcnt_r == f_jlast_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
      f_jcnt_r  <= '0;
    end else if (in_fire) begin
      f_valid_r <= (col_r >= COL_W'(2));
      f_jcnt_r  <= '0;
    end else if (f_done) begin
      f_valid_r <= 1'b0;
    end else if (v_load) begin
      f_jcnt_r  <= f_jcnt_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      f_win_r   <= {in_pixel, win_r};
      f_c_r     <= col_r - COL_W'(2);
      f_y_r     <= row_r;
      f_lo_r    <= (col_r < COL_W'(4)) ? TAP_W'(4) - col_r[TAP_W-1:0] : '0;
      f_vlo_r   <= (row_r < ROW_W'(4)) ? TAP_W'(4) - row_r[TAP_W-1:0] : '0;
      f_jlast_r <= (col_r == w_last) ? 2'd2 : 2'd0;
      f_kmax_r  <= (row_r == h_last) ? 2'd2 : 2'd0;
      f_emit_r  <= (row_r >= ROW_W'(2));
    end
  end

  // ---------------- column job stage ----------------
  assign out_free = !out_valid_r || out_ready;
  assign v_kend   = (v_kcnt_r == v_kmax_r);
  assign v_step   = v_valid_r && (!v_emit_r || out_free);
  assign v_done   = v_step && (!v_emit_r || v_kend);
  assign v_load   = f_valid_r && (!v_valid_r || v_done);

  sbe_ram #(
    .WIDTH (LINE_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk     (clk),
    .we      (v_done),
    .wr_addr (LINE_AW'(v_c_r)),
    .wr_data (wr_word),
    .re      (v_load),
    .rd_addr (LINE_AW'(f_c)),
    .rd_data (rd_word)
  );

  // offset 4 is the current row (v_h_r); lower offsets are the four rows
  // above it, slot = (row + offset) mod 4 since row-4 shares a slot
  always_comb begin
    for (int i = 0; i < TAPS; i++) begin
      v_tap[i] = fold_tap(TAP_W'(i) + TAP_W'(v_kcnt_r), v_lo_r);
      v_q[i]   = (v_tap[i] == TAP_W'(TAPS - 1)) ? v_h_r
               : rd_word[SLOT_W'(v_slot_r + v_tap[i][SLOT_W-1:0])];
    end
    v_value = blur5(v_q);
    wr_word = rd_word;
    wr_word[v_slot_r] = v_h_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_valid_r <= 1'b0;
      v_kcnt_r  <= '0;
    end else if (v_load) begin
      v_valid_r <= 1'b1;
      v_kcnt_r  <= '0;
    end else if (v_done) begin
      v_valid_r <= 1'b0;
    end else if (v_step) begin
      v_kcnt_r  <= v_kcnt_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (v_load) begin
      v_c_r       <= f_c;
      v_rbase_r   <= f_y_r - ROW_W'(2);
      v_slot_r    <= f_y_r[SLOT_W-1:0];
      v_h_r       <= f_h;
      v_lo_r      <= f_vlo_r;
      v_kmax_r    <= f_kmax_r;
      v_emit_r    <= f_emit_r;
      v_lastjob_r <= (f_jcnt_r == f_jlast_r);
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (v_step && v_emit_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (v_step && v_emit_r) begin
      out_column_r <= v_c_r;
      out_row_r    <= v_rbase_r + ROW_W'(v_kcnt_r);
      out_value_r  <= v_value;
      out_last_r   <= v_lastjob_r && v_kend;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_column = out_column_r;
  assign out_row    = out_row_r;
  assign out_value  = out_value_r;
  assign out_last   = out_last_r;

  // ---------------- assertions ----------------
  a_job_count: assert property (@(posedge clk) disable iff (!rst_n)
    f_valid_r |-> f_jcnt_r <= f_jlast_r)
    else $error("column job count past end of pixel");

  a_result_count: assert property (@(posedge clk) disable iff (!rst_n)
    v_valid_r |-> v_kcnt_r <= v_kmax_r)
    else $error("result count past end of column job");

  a_no_rmw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (v_done && v_load) |-> (v_c_r != f_c))
    else $error("line store read and write hit the same column");

  a_last_ends_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    (v_step && v_emit_r && v_lastjob_r && v_kend) |-> v_done)
    else $error("last result does not retire its column job");

endmodule
